[src/plti_pkg.sv]
// ============================================================================
// plti_pkg
// Shared types, widths and codes of the piecewise linear interpolation unit.
// ============================================================================
package plti_pkg;

    localparam int TABLE_DEPTH   = 64;
    localparam int IDX_W         = $clog2(TABLE_DEPTH);
    localparam int CNT_W         = $clog2(TABLE_DEPTH + 1);
    localparam int DATA_W        = 32;
    localparam int ALU_W         = DATA_W + 2;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int DIV_CNT_W     = $clog2(DATA_W);
    localparam int ENTRY_INDEX_W = 6;
    localparam int POINT_COUNT_W = 7;

    localparam logic OP_LOAD      = 1'b0;
    localparam logic OP_QUERY     = 1'b1;
    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_EMPTY = 1'b1;

    typedef enum logic
    {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed
    {
        alu_op_t            op;
        logic [ALU_W-1:0]   a;
        logic [ALU_W-1:0]   b;
    } alu_req_t;

    typedef struct packed
    {
        logic [DATA_W-1:0]  x;
        logic [DATA_W-1:0]  f;
    } entry_t;

    typedef struct packed
    {
        logic               en;
        logic [IDX_W-1:0]   addr;
        entry_t             entry;
    } tbl_wr_t;

    function automatic logic [ALU_W-1:0] sext(input logic [DATA_W-1:0] v);
        return {{(ALU_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    function automatic logic [ALU_W-1:0] zext(input logic [DATA_W-1:0] v);
        return {{(ALU_W-DATA_W){1'b0}}, v};
    endfunction

endpackage

[src/piecewise_linear_table_interp_unit.sv]
// ============================================================================
// piecewise_linear_table_interp_unit
// A load item (op 0) writes one breakpoint and leaves the unit ready again at
// once. A query (op 1) runs a sequencer over one shared adder, the breakpoint
// memory read port and a registered multiplier: it compares against the first
// and last points, then makes at most ceil(log2(point_count + 1)) binary
// search probes, each split into an address state and a compare state for
// the registered memory read. An interpolated value then takes a restoring
// division, one quotient bit per cycle on the shared adder, and a final add.
// The multiply and the division are skipped by an exact hit, a one-point or
// clamped query and an empty table query. Input stall is high
// for the whole query; a finished result sits in the output register, so the
// next item may be taken while the result still waits for its transfer.
// ============================================================================
module piecewise_linear_table_interp_unit
    import plti_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       op,
    input  logic [ENTRY_INDEX_W-1:0]   entry_index,
    input  logic signed [DATA_W-1:0]   entry_x,
    input  logic signed [DATA_W-1:0]   entry_f,
    input  logic signed [DATA_W-1:0]   query_y,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [DATA_W-1:0]   value,
    output logic                       status,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [POINT_COUNT_W-1:0]   cfg_data
);

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_FIRST,
        S_LAST,
        S_SEARCH,
        S_PROBE,
        S_HIT,
        S_LOW,
        S_DP,
        S_DF,
        S_MAG,
        S_MUL,
        S_DIV_INIT,
        S_DIV,
        S_ADD,
        S_FINISH
    } state_t;

    state_t                   state_reg, state_next;
    logic [POINT_COUNT_W-1:0] point_count_reg, point_count_next;
    logic                     out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]        value_reg, value_next;
    logic                     status_reg, status_next;
    logic [DATA_W-1:0]        res_value_reg, res_value_next;
    logic                     res_status_reg, res_status_next;
    logic [CNT_W-1:0]         n_reg, n_next;
    logic [CNT_W-1:0]         lo_reg, lo_next;
    logic [CNT_W-1:0]         hi_reg, hi_next;
    logic [CNT_W-1:0]         mid_reg, mid_next;
    logic [DATA_W-1:0]        y_reg, y_next;
    logic [DATA_W-1:0]        x0_reg, x0_next;
    logic [DATA_W-1:0]        f0_reg, f0_next;
    logic [DATA_W-1:0]        x1_reg, x1_next;
    logic [DATA_W-1:0]        f1_reg, f1_next;
    logic [DATA_W-1:0]        dn_reg, dn_next;
    logic [DATA_W-1:0]        dp_reg, dp_next;
    logic [DATA_W-1:0]        mag_reg, mag_next;
    logic                     neg_reg, neg_next;
    logic [DATA_W-1:0]        rem_reg, rem_next;
    logic [DATA_W-1:0]        sh_reg, sh_next;
    logic [DIV_CNT_W-1:0]     div_cnt_reg, div_cnt_next;

    tbl_wr_t           tbl_wr;
    logic [IDX_W-1:0]  rd_addr;
    entry_t            rd_data;
    alu_req_t          alu_req;
    logic [ALU_W-1:0]  alu_res;
    logic              mul_en;
    logic [PROD_W-1:0] prod;

    logic              in_xfer;
    logic              out_free;
    logic [CNT_W:0]    mid_sum;
    logic [CNT_W-1:0]  mid_val;
    logic [CNT_W-1:0]  n_query;
    logic [DATA_W:0]   trial;

    plti_table u_table
    (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    plti_alu u_alu
    (
        .req    (alu_req),
        .result (alu_res)
    );

    plti_mul u_mul
    (
        .clk  (clk),
        .en   (mul_en),
        .a    (mag_reg),
        .b    (dp_reg),
        .prod (prod)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    assign in_xfer  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_val  = mid_sum[CNT_W:1];
    assign trial    = {rem_reg, sh_reg[DATA_W-1]};

    // A count above the table depth is treated as the full table.
    assign n_query = (int'(point_count_reg) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH)
                                                          : CNT_W'(point_count_reg);

    always_comb
    begin
        state_next       = state_reg;
        point_count_next = point_count_reg;
        out_valid_next   = out_valid_reg;
        value_next       = value_reg;
        status_next      = status_reg;
        res_value_next   = res_value_reg;
        res_status_next  = res_status_reg;
        n_next           = n_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        mid_next         = mid_reg;
        y_next           = y_reg;
        x0_next          = x0_reg;
        f0_next          = f0_reg;
        x1_next          = x1_reg;
        f1_next          = f1_reg;
        dn_next          = dn_reg;
        dp_next          = dp_reg;
        mag_next         = mag_reg;
        neg_next         = neg_reg;
        rem_next         = rem_reg;
        sh_next          = sh_reg;
        div_cnt_next     = div_cnt_reg;

        tbl_wr.en          = 1'b0;
        tbl_wr.addr        = IDX_W'(entry_index);
        tbl_wr.entry.x     = entry_x;
        tbl_wr.entry.f     = entry_f;
        rd_addr            = '0;
        alu_req.op         = ALU_SUB;
        alu_req.a          = '0;
        alu_req.b          = '0;
        mul_en             = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            point_count_next = cfg_data;
        end

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                rd_addr = '0;
                if (in_xfer)
                begin
                    if (op == OP_LOAD)
                    begin
                        tbl_wr.en = (int'(entry_index) < TABLE_DEPTH);
                    end
                    else
                    begin
                        y_next = query_y;
                        n_next = n_query;
                        if (n_query == '0)
                        begin
                            res_value_next  = '0;
                            res_status_next = STATUS_EMPTY;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            res_status_next = STATUS_OK;
                            state_next      = S_FIRST;
                        end
                    end
                end
            end

            S_FIRST:
            begin
                // x[0] - y not negative means y is at or below the first point.
                alu_req.a = sext(rd_data.x);
                alu_req.b = sext(y_reg);
                rd_addr   = IDX_W'(n_reg - 1'b1);
                if (n_reg == CNT_W'(1) || !alu_res[ALU_W-1])
                begin
                    res_value_next = rd_data.f;
                    state_next     = S_FINISH;
                end
                else
                begin
                    state_next = S_LAST;
                end
            end

            S_LAST:
            begin
                alu_req.a = sext(y_reg);
                alu_req.b = sext(rd_data.x);
                if (!alu_res[ALU_W-1])
                begin
                    res_value_next = rd_data.f;
                    state_next     = S_FINISH;
                end
                else
                begin
                    lo_next    = '0;
                    hi_next    = n_reg;
                    state_next = S_SEARCH;
                end
            end

            S_SEARCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_addr    = mid_val[IDX_W-1:0];
                    mid_next   = mid_val;
                    state_next = S_PROBE;
                end
                else
                begin
                    rd_addr    = lo_reg[IDX_W-1:0];
                    state_next = S_HIT;
                end
            end

            S_PROBE:
            begin
                alu_req.a = sext(rd_data.x);
                alu_req.b = sext(y_reg);
                if (alu_res[ALU_W-1])
                begin
                    lo_next = mid_reg + 1'b1;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SEARCH;
            end

            S_HIT:
            begin
                x1_next   = rd_data.x;
                f1_next   = rd_data.f;
                alu_req.a = sext(y_reg);
                alu_req.b = sext(rd_data.x);
                rd_addr   = IDX_W'(lo_reg - 1'b1);
                if (alu_res == '0)
                begin
                    res_value_next = rd_data.f;
                    state_next     = S_FINISH;
                end
                else
                begin
                    state_next = S_LOW;
                end
            end

            S_LOW:
            begin
                x0_next    = rd_data.x;
                f0_next    = rd_data.f;
                alu_req.a  = sext(x1_reg);
                alu_req.b  = sext(rd_data.x);
                dn_next    = alu_res[DATA_W-1:0];
                state_next = S_DP;
            end

            S_DP:
            begin
                alu_req.a  = sext(y_reg);
                alu_req.b  = sext(x0_reg);
                dp_next    = alu_res[DATA_W-1:0];
                state_next = S_DF;
            end

            S_DF:
            begin
                alu_req.a  = sext(f1_reg);
                alu_req.b  = sext(f0_reg);
                neg_next   = alu_res[ALU_W-1];
                state_next = S_MAG;
            end

            S_MAG:
            begin
                alu_req.a  = neg_reg ? sext(f0_reg) : sext(f1_reg);
                alu_req.b  = neg_reg ? sext(f1_reg) : sext(f0_reg);
                mag_next   = alu_res[DATA_W-1:0];
                state_next = S_MUL;
            end

            S_MUL:
            begin
                mul_en     = 1'b1;
                state_next = S_DIV_INIT;
            end

            S_DIV_INIT:
            begin
                // The high half is already below the divisor, so the quotient
                // fits in one word.
                rem_next     = prod[PROD_W-1:DATA_W];
                sh_next      = prod[DATA_W-1:0];
                div_cnt_next = DIV_CNT_W'(DATA_W - 1);
                state_next   = S_DIV;
            end

            S_DIV:
            begin
                alu_req.a = {1'b0, trial};
                alu_req.b = zext(dn_reg);
                if (!alu_res[ALU_W-1])
                begin
                    rem_next = alu_res[DATA_W-1:0];
                    sh_next  = {sh_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[DATA_W-1:0];
                    sh_next  = {sh_reg[DATA_W-2:0], 1'b0};
                end
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == '0)
                begin
                    state_next = S_ADD;
                end
            end

            S_ADD:
            begin
                alu_req.op     = neg_reg ? ALU_SUB : ALU_ADD;
                alu_req.a      = sext(f0_reg);
                alu_req.b      = zext(sh_reg);
                res_value_next = alu_res[DATA_W-1:0];
                state_next     = S_FINISH;
            end

            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    value_next     = res_value_reg;
                    status_next    = res_status_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            point_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            point_count_reg <= point_count_next;
            out_valid_reg   <= out_valid_next;
            value_reg       <= value_next;
            status_reg      <= status_next;
            res_value_reg   <= res_value_next;
            res_status_reg  <= res_status_next;
            n_reg           <= n_next;
            lo_reg          <= lo_next;
            hi_reg          <= hi_next;
            mid_reg         <= mid_next;
            y_reg           <= y_next;
            x0_reg          <= x0_next;
            f0_reg          <= f0_next;
            x1_reg          <= x1_next;
            f1_reg          <= f1_next;
            dn_reg          <= dn_next;
            dp_reg          <= dp_next;
            mag_reg         <= mag_next;
            neg_reg         <= neg_next;
            rem_reg         <= rem_next;
            sh_reg          <= sh_next;
            div_cnt_reg     <= div_cnt_next;
        end
    end

endmodule

[src/plti_table.sv]
// ============================================================================
// plti_table
// Breakpoint memory: one write port and one read port with registered data.
// ============================================================================
module plti_table
    import plti_pkg::*;
(
    input  logic             clk,
    input  tbl_wr_t          wr,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data
);

    entry_t mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.entry;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[src/plti_alu.sv]
// ============================================================================
// plti_alu
// Shared adder and subtractor used for the breakpoint compares, the
// differences, the division steps and the final add of the sequencer.
// ============================================================================
module plti_alu
    import plti_pkg::*;
(
    input  alu_req_t         req,
    output logic [ALU_W-1:0] result
);

    always_comb
    begin
        unique case (req.op)
            ALU_ADD: result = req.a + req.b;
            ALU_SUB: result = req.a - req.b;
            default: result = req.a - req.b;
        endcase
    end

endmodule

[src/plti_mul.sv]
// ============================================================================
// plti_mul
// Registered unsigned multiplier for the slope product.
// ============================================================================
module plti_mul
    import plti_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [DATA_W-1:0] a,
    input  logic [DATA_W-1:0] b,
    output logic [PROD_W-1:0] prod
);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod <= PROD_W'(a) * PROD_W'(b);
        end
    end

endmodule

[src/plti_checker.sv]
// ============================================================================
// plti_checker
// Port-level checks of the interpolation unit, bound to the top level.
// ============================================================================
module plti_checker
    import plti_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic                     op,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic [DATA_W-1:0]        value,
    input logic                     status
);

    // A query keeps the unit busy for at least the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op == OP_QUERY |=> in_stall)
        else $error("query transfer did not make the unit busy");

    // A load is finished in its own cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op == OP_LOAD |=> !in_stall)
        else $error("load transfer left the unit busy");

    // The empty table error always carries a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STATUS_EMPTY |-> value == '0)
        else $error("empty table result with nonzero value");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value) && $stable(status))
        else $error("stalled result changed");

endmodule

bind piecewise_linear_table_interp_unit plti_checker u_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .status    (status)
);

[sim/piecewise_linear_table_interp_unit_tb.sv]
// ============================================================================
// piecewise_linear_table_interp_unit_tb
// Self-checking testbench of the breakpoint interpolation unit. The unit gets
// breakpoint loads, queries and point count writes. A scoreboard keeps its own
// copy of the table, works out the value and status of every accepted query,
// and checks each output transfer in order. Both sides idle in random bursts.
// ============================================================================
module piecewise_linear_table_interp_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import plti_pkg::*;

    localparam int ITEM_TARGET    = 1100;
    localparam int CALM_AFTER     = 950;
    localparam int DRAIN_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 2000;

    localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh80000000;
    localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFFFFFF;

    typedef struct packed
    {
        logic               status;
        logic [DATA_W-1:0]  value;
    } interp_result_t;

    class interp_scoreboard;
        logic signed [DATA_W-1:0]   bp_x [TABLE_DEPTH];
        logic signed [DATA_W-1:0]   bp_f [TABLE_DEPTH];
        logic [POINT_COUNT_W-1:0]   point_count;
        interp_result_t             awaited_q [$];
        int                         mismatches;

        function new();
            point_count = '0;
            mismatches  = 0;
            foreach (bp_x[i])
            begin
                bp_x[i] = '0;
                bp_f[i] = '0;
            end
        endfunction

        task report_mismatch(input string what);
            $display("%0t ns: mismatch: %s", $time, what);
            mismatches++;
        endtask

        function void set_point_count(input logic [POINT_COUNT_W-1:0] c);
            point_count = c;
        endfunction

        function interp_result_t interpolate(input logic signed [DATA_W-1:0] y);
            interp_result_t r;
            int unsigned    n;
            int unsigned    lo;
            int unsigned    hi;
            int unsigned    mid;
            longint         yy;
            longint         x0;
            longint         x1;
            longint         f0;
            longint         f1;
            longint         df;
            longint         dp;
            longint         dn;
            longint         q;
            longint         res;
            logic [63:0]    mag;

            n  = (point_count > TABLE_DEPTH) ? TABLE_DEPTH : point_count;
            yy = y;
            r.status = STATUS_OK;
            if (n == 0)
            begin
                r.status = STATUS_EMPTY;
                r.value  = '0;
                return r;
            end
            if (n == 1 || yy <= bp_x[0])
                res = bp_f[0];
            else if (yy >= bp_x[n-1])
                res = bp_f[n-1];
            else
            begin
                lo = 0;
                hi = n;
                while (lo < hi)
                begin
                    mid = lo + ((hi - lo) >> 1);
                    if (bp_x[mid] < yy)
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                if (lo == 0 || lo >= n)
                    res = bp_f[0];
                else
                begin
                    x1 = bp_x[lo];
                    f1 = bp_f[lo];
                    x0 = bp_x[lo-1];
                    f0 = bp_f[lo-1];
                    dn = x1 - x0;
                    dp = yy - x0;
                    if (x1 == yy)
                        res = f1;
                    else if (dn <= 0 || dp < 0)
                        res = f0;
                    else
                    begin
                        // Divide the magnitude so that the quotient truncates toward zero.
                        df  = f1 - f0;
                        mag = (df < 0) ? -df : df;
                        mag = (mag * $unsigned(dp)) / $unsigned(dn);
                        q   = longint'(mag);
                        res = (df < 0) ? f0 - q : f0 + q;
                    end
                end
            end
            r.value = res[DATA_W-1:0];
            return r;
        endfunction

        function void note_input(input logic o, input logic [ENTRY_INDEX_W-1:0] idx,
                                 input logic signed [DATA_W-1:0] ex,
                                 input logic signed [DATA_W-1:0] ef,
                                 input logic signed [DATA_W-1:0] y);
            if (o == OP_LOAD)
            begin
                bp_x[idx] = ex;
                bp_f[idx] = ef;
            end
            else
                awaited_q.push_back(interpolate(y));
        endfunction

        task check_result(input logic signed [DATA_W-1:0] v, input logic s);
            interp_result_t want;

            if (awaited_q.size() == 0)
                report_mismatch($sformatf("result with none awaited: value %h status %0d",
                                          v, s));
            else
            begin
                want = awaited_q.pop_front();
                if (s !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d", s, want.status));
                if (v !== want.value)
                    report_mismatch($sformatf("value %h, expected %h", v, want.value));
            end
        endtask

        task finish_check();
            if (awaited_q.size() != 0)
                report_mismatch($sformatf("%0d results never arrived", awaited_q.size()));
        endtask
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic                       op;
    logic [ENTRY_INDEX_W-1:0]   entry_index;
    logic signed [DATA_W-1:0]   entry_x;
    logic signed [DATA_W-1:0]   entry_f;
    logic signed [DATA_W-1:0]   query_y;
    logic                       out_valid;
    logic                       out_stall;
    logic signed [DATA_W-1:0]   value;
    logic                       status;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [POINT_COUNT_W-1:0]   cfg_data;

    interp_scoreboard           sb;
    int                         items_sent = 0;
    bit                         calm = 1'b0;
    int                         dead_cycles = 0;
    logic signed [DATA_W-1:0]   plan_x [TABLE_DEPTH];

    piecewise_linear_table_interp_unit u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .entry_index (entry_index),
        .entry_x     (entry_x),
        .entry_f     (entry_f),
        .query_y     (query_y),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .value       (value),
        .status      (status),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_input(op, entry_index, entry_x, entry_f, query_y);
        if (rst_n && out_valid && !out_stall)
            sb.check_result(value, status);
        if (rst_n && cfg_valid && cfg_ready)
            sb.set_point_count(cfg_data);
    end

    // The watchdog counts cycles without any transfer on any channel.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            dead_cycles <= 0;
        else if (dead_cycles >= WATCHDOG_LIMIT)
        begin
            $display("piecewise_linear_table_interp_unit_tb: FAIL");
            $finish;
        end
        else
            dead_cycles <= dead_cycles + 1;
    end

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            repeat ($urandom_range(1, 40)) @(posedge clk);
            if (!calm)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Valid stays high from one item to the next unless a gap is inserted.
    task automatic push_item(input logic o, input logic [ENTRY_INDEX_W-1:0] idx,
                             input logic signed [DATA_W-1:0] ex,
                             input logic signed [DATA_W-1:0] ef,
                             input logic signed [DATA_W-1:0] y);
        if (!calm && $urandom_range(0, 6) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        op          <= o;
        entry_index <= idx;
        entry_x     <= ex;
        entry_f     <= ef;
        query_y     <= y;
        do @(posedge clk); while (in_stall);
        items_sent++;
        if (items_sent >= CALM_AFTER)
            calm = 1'b1;
    endtask

    task automatic load_entry(input logic [ENTRY_INDEX_W-1:0] idx,
                              input logic signed [DATA_W-1:0] ex,
                              input logic signed [DATA_W-1:0] ef);
        push_item(OP_LOAD, idx, ex, ef, $urandom);
    endtask

    task automatic query_at(input logic signed [DATA_W-1:0] y);
        push_item(OP_QUERY, ENTRY_INDEX_W'($urandom), $urandom, $urandom, y);
    endtask

    // Let the last transfer reach the scoreboard, drain all results, then give
    // a trailing load time to land before the unit is treated as idle.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_point_count(input logic [POINT_COUNT_W-1:0] c);
        cfg_valid <= 1'b1;
        cfg_data  <= c;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_query(input int unsigned n);
        logic signed [DATA_W-1:0] y;
        int unsigned              sel;
        int unsigned              i;
        longint                   base_x;
        longint                   span;

        y   = $urandom;
        sel = $urandom_range(0, 9);
        if (n > 0 && (sel == 2 || sel == 3))
            y = plan_x[$urandom_range(0, n - 1)];
        else if (n > 0 && sel == 4)
        begin
            case ($urandom_range(0, 3))
                0: y = Q_MIN;
                1: y = Q_MAX;
                2: y = plan_x[0] - 1;
                default: y = plan_x[n-1] + 1;
            endcase
        end
        else if (n > 1 && sel >= 5)
        begin
            // Strictly inside one segment, where the division does the work.
            i      = $urandom_range(1, n - 1);
            base_x = plan_x[i-1];
            span   = longint'(plan_x[i]) - base_x;
            if (span > 1)
                y = DATA_W'(base_x + 1 + ($urandom % (span - 1)));
        end
        return y;
    endfunction

    task automatic run_directed();
        // An empty table reports an error.
        query_at(32'sh00000000);
        query_at(Q_MIN);

        // A single point gives a flat result anywhere.
        load_entry(ENTRY_INDEX_W'(0), 32'sh00000000, Q_MAX);
        settle();
        write_point_count(POINT_COUNT_W'(1));
        query_at(Q_MIN);
        query_at(Q_MAX);

        // Four points spanning the whole range with extreme values.
        load_entry(ENTRY_INDEX_W'(0), Q_MIN, Q_MAX);
        load_entry(ENTRY_INDEX_W'(1), -32'sh00010000, Q_MIN);
        load_entry(ENTRY_INDEX_W'(2), 32'sh00010000, 32'sh00000000);
        load_entry(ENTRY_INDEX_W'(3), Q_MAX, 32'sh12345678);
        settle();
        write_point_count(POINT_COUNT_W'(4));
        query_at(Q_MIN);
        query_at(Q_MAX);
        query_at(-32'sh00010000);
        query_at(32'sh00000000);
        query_at(Q_MIN + 1);
        query_at(Q_MAX - 1);

        // Break the order: the search lands on whatever segment it reaches.
        load_entry(ENTRY_INDEX_W'(1), 32'sh60000000, 32'sh00010000);
        query_at(32'sh00000000);
        query_at(32'sh70000000);
    endtask

    task automatic run_random();
        logic [POINT_COUNT_W-1:0] c;
        logic signed [DATA_W-1:0] tmp;
        int unsigned              n;
        int unsigned              phase;
        int unsigned              mode;
        int unsigned              i;
        int unsigned              j;
        int unsigned              slot;
        int                       base;

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            settle();
            case (phase)
                0: c = 7'd64;
                1: c = 7'd127;
                2: c = 7'd0;
                default:
                begin
                    case ($urandom_range(0, 9))
                        0: c = 7'd0;
                        1: c = 7'd1;
                        2: c = 7'd2;
                        3, 4, 5: c = POINT_COUNT_W'($urandom_range(3, 8));
                        6, 7: c = POINT_COUNT_W'($urandom_range(9, 64));
                        8: c = 7'd64;
                        default: c = POINT_COUNT_W'($urandom_range(65, 127));
                    endcase
                end
            endcase
            write_point_count(c);
            n = (c > TABLE_DEPTH) ? TABLE_DEPTH : c;

            // Some tables are sorted random picks, others climb in small steps with
            // an occasional repeat, and a few are left unsorted.
            mode = $urandom_range(0, 5);
            base = int'($urandom_range(0, 32'h7FFFFFFF)) - 32'sh40000000;
            for (i = 0; i < n; i++)
            begin
                if (mode >= 2 && mode <= 4)
                begin
                    if ($urandom_range(0, 3) == 0)
                        base = base + int'($urandom_range(0, 4));
                    else
                        base = base + int'($urandom_range(1, 32'h00040000));
                    plan_x[i] = base;
                end
                else
                    plan_x[i] = $urandom;
            end
            if (mode <= 1)
            begin
                for (i = 1; i < n; i++)
                begin
                    tmp = plan_x[i];
                    j   = i;
                    while (j > 0 && plan_x[j-1] > tmp)
                    begin
                        plan_x[j] = plan_x[j-1];
                        j--;
                    end
                    plan_x[j] = tmp;
                end
            end

            for (i = 0; i < n; i++)
            begin
                if ($urandom_range(0, 1) == 0)
                    load_entry(ENTRY_INDEX_W'(i), plan_x[i], $urandom);
                else
                    load_entry(ENTRY_INDEX_W'(i), plan_x[i],
                               $urandom_range(0, 32'h00200000) - 32'h00100000);
            end

            repeat ($urandom_range(10, 40))
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    // A rewrite keeps the abscissa inside the live table.
                    slot = $urandom_range(0, TABLE_DEPTH - 1);
                    if (slot < n)
                        load_entry(ENTRY_INDEX_W'(slot), plan_x[slot], $urandom);
                    else
                        load_entry(ENTRY_INDEX_W'(slot), $urandom, $urandom);
                end
                else
                    query_at(pick_query(n));
            end
            phase++;
        end
    endtask

    initial
    begin
        sb = new();
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        op          <= OP_LOAD;
        entry_index <= '0;
        entry_x     <= '0;
        entry_f     <= '0;
        query_y     <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random();
        settle();
        sb.finish_check();

        if (sb.mismatches == 0)
            $display("piecewise_linear_table_interp_unit_tb: PASS");
        else
            $display("piecewise_linear_table_interp_unit_tb: FAIL");
        $finish;
    end

endmodule

[piecewise_linear_table_interp_unit.f]
src/plti_pkg.sv
src/plti_table.sv
src/plti_alu.sv
src/plti_mul.sv
src/piecewise_linear_table_interp_unit.sv
src/plti_checker.sv
sim/piecewise_linear_table_interp_unit_tb.sv
